>>> rtl/core/dimension_list_parser_defines.svh
// Assertion macros for the dimension list parser.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef DIMENSION_LIST_PARSER_DEFINES_SVH
`define DIMENSION_LIST_PARSER_DEFINES_SVH

// Antecedent implies consequent in the same cycle, checked outside reset.
`define DLP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle, checked outside reset.
`define DLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dlp_pkg.sv
// Shared types and constants for the dimension list parser.
// No dependencies; used by dimension_list_parser.
`default_nettype none

package dlp_pkg;

  localparam int CHAR_W = 21;
  localparam int INT_WIDTH = 32;
  localparam int INT_PROD_W = INT_WIDTH + 4;
  localparam int FRAC_W = 30;
  localparam int FRAC_CNT_W = 4;
  localparam int KIND_W = 2;

  localparam logic [FRAC_CNT_W-1:0] MAX_FRACTION_DIGITS = 4'd9;

  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;

  localparam logic [CHAR_W-1:0] CHAR_COMMA = 21'h00002C;
  localparam logic [CHAR_W-1:0] CHAR_DOT = 21'h00002E;
  localparam logic [CHAR_W-1:0] CHAR_PERCENT = 21'h000025;
  localparam logic [CHAR_W-1:0] CHAR_STAR = 21'h00002A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 21'h000020;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 21'h000009;
  localparam logic [CHAR_W-1:0] CHAR_LF = 21'h00000A;
  localparam logic [CHAR_W-1:0] CHAR_FF = 21'h00000C;
  localparam logic [CHAR_W-1:0] CHAR_CR = 21'h00000D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 21'h000030;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 21'h000039;

  typedef enum logic [KIND_W-1:0] {
    KIND_ABS = 2'd0,
    KIND_PCT = 2'd1,
    KIND_REL = 2'd2
  } kind_t;

  typedef struct packed {
    logic                  has_dimension;
    logic [INT_WIDTH-1:0]  int_part;
    logic [FRAC_W-1:0]     frac_numerator;
    logic [FRAC_CNT_W-1:0] frac_digits;
    kind_t                 kind;
    logic                  saturated;
    logic                  end_of_list;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/dimension_list_parser.sv
// Top level of the dimension list parser: character-by-character token parser.
// Depends on dlp_pkg and dimension_list_parser_defines.svh.
// The block takes one character beat per cycle and registers any result that the beat
// yields. Commas split the text into tokens; each nonempty token, and the beat
// flagged last in every case, yields one result holding the integer part, the kept fraction
// digits and the suffix kind. An output register backed by one skid entry holds one more
// result while the output stalls, and beats that yield no result keep flowing; input ready
// drops only while the skid entry is occupied. The per-beat path is one multiply by ten
// and an add.
`default_nettype none
`include "dimension_list_parser_defines.svh"

module dimension_list_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [dlp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // char_code, zero fill
  input  wire logic                            s_axis_tlast,   // end_of_string
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // int_part, frac_numerator, frac_digits, saturated, zero fill
  output logic [dlp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [dlp_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,   // has_dimension, kind
  output logic                                 m_axis_tlast    // end_of_list
);

  typedef enum logic [1:0] {
    PH_INT,
    PH_FRAC,
    PH_WS,
    PH_DONE
  } phase_t;

  phase_t                            phase, phase_next, t_phase;
  logic                              token_nonempty, token_nonempty_next;
  logic [dlp_pkg::INT_WIDTH-1:0]     int_accum, int_accum_next, t_int;
  logic                              int_overflow, int_overflow_next, t_ovf;
  logic [dlp_pkg::FRAC_W-1:0]        frac_accum, frac_accum_next, t_frac;
  logic [dlp_pkg::FRAC_CNT_W-1:0]    frac_count, frac_count_next, t_cnt;
  dlp_pkg::kind_t                    token_kind, token_kind_next, t_kind;

  dlp_pkg::result_t                  out_res, skid_res, res;
  logic                              out_valid, skid_valid;

  logic [dlp_pkg::CHAR_W-1:0]        c;
  logic                              last, accept, emit, is_comma, is_digit, is_ws;
  logic [3:0]                        digit;
  logic [dlp_pkg::INT_PROD_W-1:0]    int_prod;
  logic [dlp_pkg::FRAC_W-1:0]        frac_prod;

  assign c        = s_axis_tdata[dlp_pkg::CHAR_W-1:0];
  assign last     = s_axis_tlast;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_comma = (c == dlp_pkg::CHAR_COMMA);
  assign is_digit = (c >= dlp_pkg::CHAR_ZERO) && (c <= dlp_pkg::CHAR_NINE);
  assign is_ws    = (c == dlp_pkg::CHAR_TAB) || (c == dlp_pkg::CHAR_LF) ||
                    (c == dlp_pkg::CHAR_FF) || (c == dlp_pkg::CHAR_CR) ||
                    (c == dlp_pkg::CHAR_SPACE);
  assign digit    = c[3:0];

  assign int_prod  = {4'd0, int_accum} * dlp_pkg::INT_PROD_W'(10)
                     + dlp_pkg::INT_PROD_W'(digit);
  assign frac_prod = frac_accum * dlp_pkg::FRAC_W'(10) + dlp_pkg::FRAC_W'(digit);

  always_comb begin
    t_phase = phase;
    t_int   = int_accum;
    t_ovf   = int_overflow;
    t_frac  = frac_accum;
    t_cnt   = frac_count;
    t_kind  = token_kind;

    unique case (phase)
      PH_INT: begin
        if (is_digit) begin
          if (int_overflow || (int_prod[dlp_pkg::INT_PROD_W-1:dlp_pkg::INT_WIDTH] != 4'd0)) begin
            t_int = '1;
            t_ovf = 1'b1;
          end else begin
            t_int = int_prod[dlp_pkg::INT_WIDTH-1:0];
          end
        end else if (c == dlp_pkg::CHAR_DOT) begin
          t_phase = PH_FRAC;
        end else begin
          t_phase = is_ws ? PH_WS : PH_DONE;
          if (c == dlp_pkg::CHAR_PERCENT) begin
            t_kind = dlp_pkg::KIND_PCT;
          end else if (c == dlp_pkg::CHAR_STAR) begin
            t_kind = dlp_pkg::KIND_REL;
          end
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (frac_count < dlp_pkg::MAX_FRACTION_DIGITS) begin
            t_frac = frac_prod;
            t_cnt  = frac_count + 4'd1;
          end
        end else if (c != dlp_pkg::CHAR_SPACE) begin
          t_phase = is_ws ? PH_WS : PH_DONE;
          if (c == dlp_pkg::CHAR_PERCENT) begin
            t_kind = dlp_pkg::KIND_PCT;
          end else if (c == dlp_pkg::CHAR_STAR) begin
            t_kind = dlp_pkg::KIND_REL;
          end
        end
      end
      PH_WS: begin
        t_phase = is_ws ? PH_WS : PH_DONE;
        if (c == dlp_pkg::CHAR_PERCENT) begin
          t_kind = dlp_pkg::KIND_PCT;
        end else if (c == dlp_pkg::CHAR_STAR) begin
          t_kind = dlp_pkg::KIND_REL;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.end_of_list = last;
    if (is_comma) begin
      emit              = token_nonempty || last;
      res.has_dimension = token_nonempty;
      res.int_part      = token_nonempty ? int_accum : '0;
      res.frac_numerator = token_nonempty ? frac_accum : '0;
      res.frac_digits   = token_nonempty ? frac_count : '0;
      res.kind          = token_nonempty ? token_kind : dlp_pkg::KIND_ABS;
      res.saturated     = token_nonempty && int_overflow;
    end else begin
      emit              = last;
      res.has_dimension = 1'b1;
      res.int_part      = t_int;
      res.frac_numerator = t_frac;
      res.frac_digits   = t_cnt;
      res.kind          = t_kind;
      res.saturated     = t_ovf;
    end

    if (is_comma || last) begin
      phase_next          = PH_INT;
      token_nonempty_next = 1'b0;
      int_accum_next      = '0;
      int_overflow_next   = 1'b0;
      frac_accum_next     = '0;
      frac_count_next     = '0;
      token_kind_next     = dlp_pkg::KIND_ABS;
    end else begin
      phase_next          = t_phase;
      token_nonempty_next = 1'b1;
      int_accum_next      = t_int;
      int_overflow_next   = t_ovf;
      frac_accum_next     = t_frac;
      frac_count_next     = t_cnt;
      token_kind_next     = t_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_INT;
      token_nonempty <= 1'b0;
      int_accum      <= '0;
      int_overflow   <= 1'b0;
      frac_accum     <= '0;
      frac_count     <= '0;
      token_kind     <= dlp_pkg::KIND_ABS;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        token_nonempty <= token_nonempty_next;
        int_accum      <= int_accum_next;
        int_overflow   <= int_overflow_next;
        frac_accum     <= frac_accum_next;
        frac_count     <= frac_count_next;
        token_kind     <= token_kind_next;
      end
      if (m_axis_tready || !out_valid) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else if (accept && emit) begin
          out_res   <= res;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (accept && emit) begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.saturated, out_res.frac_digits,
                          out_res.frac_numerator, out_res.int_part};
  assign m_axis_tuser  = {out_res.kind, out_res.has_dimension};
  assign m_axis_tlast  = out_res.end_of_list;

  `DLP_ASSERT_SAME(a_skid_behind_out, clk, rst, skid_valid, out_valid,
    "skid entry occupied while the output register is empty")
  `DLP_ASSERT_NEXT(a_clear_after_last, clk, rst, accept && last,
    phase == PH_INT && !token_nonempty && int_accum == '0 && frac_count == '0,
    "token state not cleared after the last beat")
  `DLP_ASSERT_SAME(a_empty_result_zero, clk, rst, out_valid && !out_res.has_dimension,
    out_res.int_part == '0 && out_res.frac_numerator == '0 && !out_res.saturated &&
    out_res.end_of_list,
    "empty result carries a value or is not an end marker")
  `DLP_ASSERT_SAME(a_frac_count_bound, clk, rst, 1'b1,
    frac_count <= dlp_pkg::MAX_FRACTION_DIGITS,
    "fraction digit count beyond its limit")

endmodule

`default_nettype wire
